// ===== src/kslpd_pkg.sv =====
// Shared types and constants for the key short/long press detector.
// No dependencies; imported by every module of the block.
package kslpd_pkg;

  localparam int KEYS_DEF = 3;

  localparam int PIN_W = 3;
  localparam int IDX_W = 2;
  localparam int CNT_W = 16;
  localparam int EV_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CNT_W-1:0] LONG_RST     = 16'd3000;
  localparam logic [PIN_W-1:0] ACTIVE_RST   = 3'd4;
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 2'd2;

  typedef struct packed {
    logic             sample;
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] long_press;
  } lane_ctrl_t;

endpackage

// ===== src/kslpd_lane.sv =====
// One key lane: press state, saturating held counter and latched event.
// Depends on kslpd_pkg.
module kslpd_lane
  import kslpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  lane_ctrl_t      ctrl,
  input  logic            pin,
  input  logic            act,
  input  logic            clear,
  output logic [EV_W-1:0] pending
);

  logic             held_r, held_nxt;
  logic             fired_r, fired_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EV_W-1:0]  ev_r, ev_nxt;
  logic [CNT_W-1:0] inc;
  logic [CNT_W-1:0] elapsed;
  logic             fired_eff;

  assign inc       = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign elapsed   = held_r ? inc : '0;
  assign fired_eff = held_r ? fired_r : 1'b0;
  assign pending   = ev_r;

  always_comb begin
    held_nxt  = held_r;
    fired_nxt = fired_r;
    cnt_nxt   = cnt_r;
    ev_nxt    = ev_r;
    if (clear) begin
      ev_nxt = EV_NONE;
    end
    if (ctrl.sample) begin
      if (pin == act) begin
        held_nxt  = 1'b1;
        cnt_nxt   = elapsed;
        fired_nxt = fired_eff;
        if (elapsed >= ctrl.debounce && elapsed >= ctrl.long_press && !fired_eff) begin
          ev_nxt    = EV_LONG;
          fired_nxt = 1'b1;
        end
      end else begin
        if (held_r && inc >= ctrl.debounce && inc < ctrl.long_press && !fired_r) begin
          ev_nxt = EV_SHORT;
        end
        held_nxt  = 1'b0;
        fired_nxt = 1'b0;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      fired_r <= 1'b0;
      cnt_r   <= '0;
      ev_r    <= EV_NONE;
    end else begin
      held_r  <= held_nxt;
      fired_r <= fired_nxt;
      cnt_r   <= cnt_nxt;
      ev_r    <= ev_nxt;
    end
  end

endmodule

// ===== src/kslpd_merge.sv =====
// Merge stage: select the addressed lane's event, issue its clear, register the result beat.
// Depends on kslpd_pkg.
module kslpd_merge
  import kslpd_pkg::*;
#(
  parameter int KEYS = KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_beat,
  input  logic [IDX_W-1:0]           key_index,
  input  logic [KEYS-1:0][EV_W-1:0]  pending,
  output logic [KEYS-1:0]            clear,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [EV_W-1:0]            out_event_code,
  output logic                       can_take
);

  logic            valid_r, valid_nxt;
  logic [EV_W-1:0] code_r, code_nxt;
  logic [EV_W-1:0] sel;

  always_comb begin
    sel = EV_NONE;
    for (int k = 0; k < KEYS; k++) begin
      clear[k] = rd_beat && (32'(key_index) == k);
      if (32'(key_index) == k) begin
        sel = sel | pending[k];
      end
    end
  end

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    code_nxt  = code_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (rd_beat) begin
      valid_nxt = 1'b1;
      code_nxt  = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign out_valid      = valid_r;
  assign out_event_code = code_r;

endmodule

// ===== src/key_short_long_press_detector_core.sv =====
// Top level of the key short/long press detector: config registers, key lanes, merge stage.
// Depends on kslpd_pkg, kslpd_lane and kslpd_merge.
//
// A sample beat updates every key lane in parallel in the
// cycle it is accepted, and a read beat returns the addressed key's event through a one-deep
// output register on the next cycle and clears it. A beat is accepted every cycle while the
// output register is empty or being drained; only a stalled result holds off new beats.
// Active level, debounce and long-press thresholds are written through the cfg_ port while idle.
module key_short_long_press_detector_core
  import kslpd_pkg::*;
#(
  parameter int KEYS = KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [PIN_W-1:0]      in_pin_levels,
  input  logic [IDX_W-1:0]      in_key_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EV_W-1:0]       out_event_code
);

  logic [CNT_W-1:0] debounce_r;
  logic [CNT_W-1:0] long_r;
  logic [PIN_W-1:0] active_r;

  logic                      beat;
  logic                      can_take;
  lane_ctrl_t                ctrl;
  logic [KEYS-1:0][EV_W-1:0] pending;
  logic [KEYS-1:0]           clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      active_r   <= ACTIVE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_wdata;
        REG_LONG:     long_r     <= cfg_wdata;
        REG_ACTIVE:   active_r   <= cfg_wdata[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = can_take;
  assign beat     = in_valid && can_take;

  assign ctrl.sample     = beat && (in_operation == OP_SAMPLE);
  assign ctrl.debounce   = debounce_r;
  assign ctrl.long_press = long_r;

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    logic pin;
    logic act;
    if (k < PIN_W) begin : g_pin
      assign pin = in_pin_levels[k];
      assign act = active_r[k];
    end else begin : g_nopin
      assign pin = 1'b0;
      assign act = 1'b0;
    end

    kslpd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .pin     (pin),
      .act     (act),
      .clear   (clear[k]),
      .pending (pending[k])
    );
  end

  kslpd_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_beat        (beat && (in_operation == OP_READ)),
    .key_index      (in_key_index),
    .pending        (pending),
    .clear          (clear),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_event_code (out_event_code),
    .can_take       (can_take)
  );

endmodule

// ===== tb/sv/key_short_long_press_detector_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for key_short_long_press_detector_core: queued driver with bursts,
// stalling receiver, and an in-bench model of the per-key press timers. Needs kslpd_pkg.
module key_short_long_press_detector_core_test;
  import kslpd_pkg::*;

  typedef struct packed {
    logic             op;
    logic [PIN_W-1:0] pins;
    logic [IDX_W-1:0] idx;
  } key_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_SAMPLE;
  logic [PIN_W-1:0]      in_pin_levels = '0;
  logic [IDX_W-1:0]      in_key_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [EV_W-1:0]       out_event_code;

  key_beat_t       beat_q[$];
  logic [EV_W-1:0] read_events_q[$];
  int              err_cnt = 0;

  // Press-timer model state and its copy of the registers
  logic [CNT_W-1:0] db_thr;
  logic [CNT_W-1:0] lp_thr;
  logic [PIN_W-1:0] act_lvl;
  logic             pressed[KEYS_DEF];
  logic             long_done[KEYS_DEF];
  logic [CNT_W-1:0] hold_cnt[KEYS_DEF];
  logic [EV_W-1:0]  latched_ev[KEYS_DEF];

  int   burst_left = 0;
  int   gap_left = 0;
  int   rx_mode = 0;
  int   mode_left = 0;
  int   stall_left = 0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  key_short_long_press_detector_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_pin_levels  (in_pin_levels),
    .in_key_index   (in_key_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    if (err_cnt < 40) $display("ERROR %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic step_keys(input logic [PIN_W-1:0] pins);
    logic [CNT_W-1:0] elapsed;
    for (int k = 0; k < KEYS_DEF; k++) begin
      if (pins[k] == act_lvl[k]) begin
        if (!pressed[k]) begin
          pressed[k] = 1'b1;
          long_done[k] = 1'b0;
          elapsed = '0;
        end else begin
          elapsed = (hold_cnt[k] == CNT_MAX) ? CNT_MAX : hold_cnt[k] + 1'b1;
        end
        hold_cnt[k] = elapsed;
        if (elapsed >= db_thr && elapsed >= lp_thr && !long_done[k]) begin
          latched_ev[k] = EV_LONG;
          long_done[k] = 1'b1;
        end
      end else begin
        if (pressed[k]) begin
          elapsed = (hold_cnt[k] == CNT_MAX) ? CNT_MAX : hold_cnt[k] + 1'b1;
          if (elapsed >= db_thr && elapsed < lp_thr && !long_done[k]) latched_ev[k] = EV_SHORT;
        end
        pressed[k] = 1'b0;
        long_done[k] = 1'b0;
        hold_cnt[k] = '0;
      end
    end
  endtask

  task automatic take_beat(input key_beat_t b);
    if (b.op == OP_SAMPLE) begin
      step_keys(b.pins);
    end else if (b.idx < KEYS_DEF) begin
      read_events_q.push_back(latched_ev[b.idx]);
      latched_ev[b.idx] = EV_NONE;
    end else begin
      read_events_q.push_back(EV_NONE);
    end
  endtask

  // Driver: bursts with random gaps, holds the beat while stalled
  always @(posedge clk) begin : drv_blk
    key_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (beat_q.size() != 0) begin
      nxt = beat_q.pop_front();
      in_valid <= 1'b1;
      in_operation <= nxt.op;
      in_pin_levels <= nxt.pins;
      in_key_index <= nxt.idx;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: own stall pattern plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_ready <= 1'b0;
      stall_left <= 400;
      hold_off_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(1, 12);
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: check the drained beat, then advance the model on the accepted one
  always @(posedge clk) begin : mon_blk
    logic [EV_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (read_events_q.size() == 0) begin
          flag_error($sformatf("result %0d with no read pending", out_event_code));
        end else begin
          want = read_events_q.pop_front();
          if (out_event_code !== want)
            flag_error($sformatf("event_code %0d, want %0d", out_event_code, want));
        end
      end
      if (in_valid && in_ready)
        take_beat('{op: in_operation, pins: in_pin_levels, idx: in_key_index});
    end
  end

  task automatic queue_sample(input logic [PIN_W-1:0] pins);
    beat_q.push_back('{op: OP_SAMPLE, pins: pins, idx: IDX_W'($urandom)});
  endtask

  task automatic queue_read(input logic [IDX_W-1:0] idx);
    beat_q.push_back('{op: OP_READ, pins: PIN_W'($urandom), idx: idx});
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0 || in_valid || read_events_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] db, input logic [15:0] lp,
                            input logic [15:0] act_word);
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= db;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_index <= REG_LONG;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_index <= REG_ACTIVE;
    cfg_wdata <= act_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    db_thr = db;
    lp_thr = lp;
    act_lvl = act_word[PIN_W-1:0];
  endtask

  task automatic queue_session(input int n);
    int cnt;
    int len;
    int lim;
    logic [PIN_W-1:0] p;
    cnt = 0;
    lim = (lp_thr > 24) ? 28 : int'(lp_thr) + 4;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) != 0) queue_sample(PIN_W'($urandom));
        else queue_read(IDX_W'($urandom));
        cnt++;
      end else begin
        p = PIN_W'($urandom);
        len = $urandom_range(1, lim);
        repeat (len) queue_sample(p);
        cnt += len;
        while ($urandom_range(0, 9) < 5) begin
          queue_read(IDX_W'($urandom_range(0, 3)));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    logic [15:0] act_word;
    db_thr = DEBOUNCE_RST;
    lp_thr = LONG_RST;
    act_lvl = ACTIVE_RST;
    for (int k = 0; k < KEYS_DEF; k++) begin
      pressed[k] = 1'b0;
      long_done[k] = 1'b0;
      hold_cnt[k] = '0;
      latched_ev[k] = EV_NONE;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset thresholds: empty reads, debounced short press, bounce too brief to count
    for (int i = 0; i < 4; i++) queue_read(IDX_W'(i));
    repeat (12) queue_sample(3'b100);
    queue_sample(3'b011);
    for (int i = 0; i < 4; i++) queue_read(IDX_W'(i));
    repeat (3) queue_sample(3'b100);
    queue_sample(3'b011);
    queue_read(2'd2);
    wait_drained();

    // Zero thresholds: long fires on first pressed tick, never a short
    set_config(16'd0, 16'd0, 16'd7);
    queue_sample(3'b111);
    for (int i = 0; i < 3; i++) queue_read(IDX_W'(i));
    queue_sample(3'b000);
    queue_sample(3'b111);
    queue_sample(3'b111);
    queue_sample(3'b000);
    queue_read(2'd0);
    queue_read(2'd1);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(16'hFFFF, 16'd0, 16'd0);
        1: set_config(16'd0, 16'hFFFF, 16'd7);
        2: set_config(16'd6, 16'd3, 16'd5);
        default: begin
          act_word = {13'd0, PIN_W'($urandom)};
          if ($urandom_range(0, 3) == 0) act_word[15:PIN_W] = 13'($urandom);
          set_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 24)), act_word);
        end
      endcase
      if (ph == 3) hold_off_req <= 1'b1;
      queue_session(105);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
